// ===== rtl/aitv_pkg.sv =====
// Package for the IP address text validator.
// Holds the transaction payload types, the per-text state type and the fault codes.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package aitv_pkg;

    localparam logic [7:0] CHAR_DOT     = 8'd46;
    localparam logic [7:0] CHAR_COLON   = 8'd58;
    localparam logic [7:0] CHAR_ZERO    = 8'd48;
    localparam logic [7:0] CHAR_NINE    = 8'd57;
    localparam logic [7:0] CHAR_UPPER_A = 8'd65;
    localparam logic [7:0] CHAR_UPPER_F = 8'd70;
    localparam logic [7:0] CHAR_LOWER_A = 8'd97;
    localparam logic [7:0] CHAR_LOWER_F = 8'd102;

    localparam logic [8:0] GROUP_VALUE_MAX = 9'd255;
    localparam logic [8:0] GROUP_VALUE_SAT = 9'd256;
    localparam logic [3:0] IPV4_GROUPS     = 4'd4;
    localparam logic [3:0] IPV6_GROUPS     = 4'd8;
    localparam logic [2:0] IPV6_MAX_DIGITS = 3'd4;
    localparam logic [3:0] GROUP_COUNT_SAT = 4'd15;
    localparam logic [2:0] DIGITS_SAT      = 3'd7;
    localparam logic [8:0] COLON_RUN_SAT   = 9'd3;

    typedef enum logic [2:0] {
        FAULT_NONE        = 3'd0,
        FAULT_BAD_CHAR    = 3'd1,
        FAULT_OVER_255    = 3'd2,
        FAULT_GROUP_COUNT = 3'd3,
        FAULT_EMPTY_GROUP = 3'd4,
        FAULT_SECOND_DC   = 3'd5,
        FAULT_GROUP_LONG  = 3'd6
    } fault_t;

    typedef struct packed {
        logic [7:0] char_code;
        logic       last_char;
    } in_data_t;

    typedef struct packed {
        logic       address_valid;
        logic [2:0] fault_code;
    } out_data_t;

    typedef struct packed {
        logic [3:0] group_count;
        logic [8:0] group_value;
        logic [2:0] digits_in_group;
        logic       double_colon_seen;
        fault_t     first_fault;
    } text_state_t;

    localparam text_state_t TEXT_STATE_CLEAR = '{
        group_count:       4'd0,
        group_value:       9'd0,
        digits_in_group:   3'd0,
        double_colon_seen: 1'b0,
        first_fault:       FAULT_NONE
    };

endpackage

`default_nettype wire

// ===== rtl/aitv_step_logic.sv =====
// Per-character update of the address text state and the end-of-text result.
// Depends on aitv_pkg.
`timescale 1ns / 1ps
`default_nettype none

module aitv_step_logic
    import aitv_pkg::*;
(
    input  wire logic        mode_ipv6,
    input  wire text_state_t state_cur,
    input  wire in_data_t    char_in,
    output text_state_t      state_new,
    output out_data_t        result
);

    always_comb begin
        text_state_t st;
        logic [7:0]  c;
        logic        is_dec;
        logic        is_hex;
        logic [11:0] v;
        logic [4:0]  groups;
        logic        group_open;

        st         = state_cur;
        c          = char_in.char_code;
        is_dec     = (c >= CHAR_ZERO) && (c <= CHAR_NINE);
        is_hex     = is_dec || ((c >= CHAR_UPPER_A) && (c <= CHAR_UPPER_F)) ||
                     ((c >= CHAR_LOWER_A) && (c <= CHAR_LOWER_F));
        v          = '0;
        groups     = '0;
        group_open = 1'b0;

        if (!mode_ipv6) begin
            if (is_dec) begin
                v = {st.group_value, 3'b000} + {2'b00, st.group_value, 1'b0}
                    + {4'd0, c - CHAR_ZERO};
                if (v > {3'd0, GROUP_VALUE_MAX}) begin
                    st.group_value = GROUP_VALUE_SAT;
                    if (st.first_fault == FAULT_NONE) st.first_fault = FAULT_OVER_255;
                end else begin
                    st.group_value = v[8:0];
                end
                if (st.digits_in_group < DIGITS_SAT) st.digits_in_group += 3'd1;
            end else if (c == CHAR_DOT) begin
                if (st.digits_in_group == '0 && st.first_fault == FAULT_NONE) begin
                    st.first_fault = FAULT_EMPTY_GROUP;
                end
                if (st.group_count < GROUP_COUNT_SAT) st.group_count += 4'd1;
                st.group_value     = '0;
                st.digits_in_group = '0;
            end else if (st.first_fault == FAULT_NONE) begin
                st.first_fault = FAULT_BAD_CHAR;
            end
            if (char_in.last_char && st.first_fault == FAULT_NONE) begin
                if (st.digits_in_group == '0) begin
                    st.first_fault = FAULT_EMPTY_GROUP;
                end else if (st.group_count + 4'd1 != IPV4_GROUPS) begin
                    st.first_fault = FAULT_GROUP_COUNT;
                end
            end
        end else begin
            if (is_hex) begin
                // A single leading colon leaves an empty first group.
                if (st.group_value == 9'd1 && st.group_count == '0 &&
                    !st.double_colon_seen && st.first_fault == FAULT_NONE) begin
                    st.first_fault = FAULT_EMPTY_GROUP;
                end
                if (st.digits_in_group >= IPV6_MAX_DIGITS &&
                    st.first_fault == FAULT_NONE) begin
                    st.first_fault = FAULT_GROUP_LONG;
                end
                if (st.digits_in_group < DIGITS_SAT) st.digits_in_group += 3'd1;
                st.group_value = '0;
            end else if (c == CHAR_COLON) begin
                // In IPv6 mode the group value register counts the current colon run.
                if (st.group_value < COLON_RUN_SAT) st.group_value += 9'd1;
                if (st.group_value == 9'd1) begin
                    if (st.digits_in_group != '0 && st.group_count < GROUP_COUNT_SAT) begin
                        st.group_count += 4'd1;
                    end
                    st.digits_in_group = '0;
                end else if (st.group_value == 9'd2) begin
                    if (st.double_colon_seen && st.first_fault == FAULT_NONE) begin
                        st.first_fault = FAULT_SECOND_DC;
                    end
                    st.double_colon_seen = 1'b1;
                end else if (st.first_fault == FAULT_NONE) begin
                    st.first_fault = FAULT_SECOND_DC;
                end
            end else if (st.first_fault == FAULT_NONE) begin
                st.first_fault = FAULT_BAD_CHAR;
            end
            // One bit wider than the count, since a saturated count plus an open group is 16.
            group_open = (st.digits_in_group != '0);
            groups     = {1'b0, st.group_count} + {4'd0, group_open};
            if (char_in.last_char && st.first_fault == FAULT_NONE) begin
                if (st.group_value == 9'd1) begin
                    st.first_fault = FAULT_EMPTY_GROUP;
                end else if (st.double_colon_seen ?
                             (groups > ({1'b0, IPV6_GROUPS} - 5'd1)) :
                             (groups != {1'b0, IPV6_GROUPS})) begin
                    st.first_fault = FAULT_GROUP_COUNT;
                end
            end
        end

        result.address_valid = (st.first_fault == FAULT_NONE);
        result.fault_code    = st.first_fault;
        // The closing character returns the text state to its cleared value.
        state_new = char_in.last_char ? TEXT_STATE_CLEAR : st;
    end

endmodule

`default_nettype wire

// ===== rtl/ip_address_text_validator_top.sv =====
// Path: a closing character is held in the input register, and its result is then
// registered in the result register, from which it is taken.
// Throughput: one character per cycle; a closing character waits in the input register
// while the previous result has not been taken.
// Reset (aresetn, synchronous, active low) selects IPv4 mode and clears the text state.
// A mode write also clears the text state. Depends on aitv_pkg and aitv_step_logic.
`timescale 1ns / 1ps
`default_nettype none

module ip_address_text_validator_top
    import aitv_pkg::*;
(
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      cfg_valid,
    output logic           cfg_ready,
    input  wire logic      cfg_data,
    input  wire logic      s_valid,
    output logic           s_ready,
    input  wire in_data_t  s_data,
    output logic           m_valid,
    input  wire logic      m_ready,
    output out_data_t      m_data
);

    logic        mode_reg;
    text_state_t state_reg;
    text_state_t state_next;
    logic        in_valid_reg;
    in_data_t    in_data_reg;
    logic        m_valid_reg;
    out_data_t   m_data_reg;
    out_data_t   result_next;
    logic        fire;

    aitv_step_logic u_step (
        .mode_ipv6 (mode_reg),
        .state_cur (state_reg),
        .char_in   (in_data_reg),
        .state_new (state_next),
        .result    (result_next)
    );

    // A non-closing character never needs the result slot.
    assign fire = in_valid_reg &&
                  (!in_data_reg.last_char || !m_valid_reg || m_ready);

    assign s_ready   = !in_valid_reg || fire;
    assign cfg_ready = 1'b1;
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg     <= 1'b0;
            state_reg    <= TEXT_STATE_CLEAR;
            in_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (cfg_valid) begin
                mode_reg  <= cfg_data;
                state_reg <= TEXT_STATE_CLEAR;
            end else if (fire) begin
                state_reg <= state_next;
            end

            if (s_valid && s_ready) begin
                in_valid_reg <= 1'b1;
            end else if (fire) begin
                in_valid_reg <= 1'b0;
            end

            if (fire && in_data_reg.last_char) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_data_reg <= s_data;
        end
        if (fire && in_data_reg.last_char) begin
            m_data_reg <= result_next;
        end
    end

endmodule

`default_nettype wire

// ===== tb/ip_address_text_validator_top_tb.sv =====
// Self-checking testbench for ip_address_text_validator_top: IPv4 and IPv6 address texts.
// It streams directed and random texts, predicts each verdict in a scoreboard class and checks it.
// Depends on aitv_pkg and the RTL of the validator.
`timescale 1ns / 1ps

module ip_address_text_validator_top_tb;
    import aitv_pkg::*;

    localparam logic [7:0] ASCII_DOT   = 8'h2E;
    localparam logic [7:0] ASCII_COLON = 8'h3A;
    localparam logic [7:0] ASCII_0     = 8'h30;
    localparam logic [7:0] ASCII_9     = 8'h39;
    localparam logic [7:0] ASCII_UA    = 8'h41;
    localparam logic [7:0] ASCII_UF    = 8'h46;
    localparam logic [7:0] ASCII_LA    = 8'h61;
    localparam logic [7:0] ASCII_LF    = 8'h66;
    localparam logic       MODE_IPV4   = 1'b0;
    localparam logic       MODE_IPV6   = 1'b1;
    localparam int         ITEMS_PER_BLOCK = 150;

    typedef logic [7:0] char_q_t[$];

    class address_verdict_board;
        logic       ipv6_mode;
        logic [3:0] grp_cnt;
        logic [8:0] grp_val;     // IPv4 group value, or IPv6 colon run length
        logic [2:0] grp_digits;
        logic       dc_seen;
        fault_t     cur_fault;
        out_data_t  verdict_q[$];
        int         texts_checked;
        int         failures;

        function new();
            ipv6_mode     = MODE_IPV4;
            texts_checked = 0;
            failures      = 0;
            clear_text();
        endfunction

        function void clear_text();
            grp_cnt    = '0;
            grp_val    = '0;
            grp_digits = '0;
            dc_seen    = 1'b0;
            cur_fault  = FAULT_NONE;
        endfunction

        function void log_fault(fault_t f);
            if (cur_fault == FAULT_NONE) cur_fault = f;
        endfunction

        function void note_mode(logic m);
            ipv6_mode = m;
            clear_text();
        endfunction

        function int pending();
            return verdict_q.size();
        endfunction

        // Advances the predicted text state by one accepted character.
        function void note_char(in_data_t d);
            logic [7:0] c;
            int         v;
            int         groups;
            logic       is_hex;
            out_data_t  exp_r;
            c = d.char_code;
            is_hex = (c >= ASCII_0 && c <= ASCII_9) || (c >= ASCII_UA && c <= ASCII_UF) ||
                     (c >= ASCII_LA && c <= ASCII_LF);
            if (ipv6_mode == MODE_IPV4) begin
                if (c >= ASCII_0 && c <= ASCII_9) begin
                    v = int'(grp_val) * 10 + int'(c) - int'(ASCII_0);
                    if (v > 255) begin
                        v = 256;
                        log_fault(FAULT_OVER_255);
                    end
                    grp_val = v[8:0];
                    if (grp_digits != 3'd7) grp_digits++;
                end else if (c == ASCII_DOT) begin
                    if (grp_digits == 0) log_fault(FAULT_EMPTY_GROUP);
                    if (grp_cnt != 4'd15) grp_cnt++;
                    grp_val    = '0;
                    grp_digits = '0;
                end else begin
                    log_fault(FAULT_BAD_CHAR);
                end
                if (d.last_char && cur_fault == FAULT_NONE) begin
                    if (grp_digits == 0) log_fault(FAULT_EMPTY_GROUP);
                    else if (int'(grp_cnt) + 1 != 4) log_fault(FAULT_GROUP_COUNT);
                end
            end else begin
                if (is_hex) begin
                    // A lone colon ahead of the first group is an empty group.
                    if (grp_val == 1 && grp_cnt == 0 && !dc_seen) log_fault(FAULT_EMPTY_GROUP);
                    if (grp_digits >= 4) log_fault(FAULT_GROUP_LONG);
                    if (grp_digits != 3'd7) grp_digits++;
                    grp_val = '0;
                end else if (c == ASCII_COLON) begin
                    if (grp_val < 3) grp_val++;
                    if (grp_val == 1) begin
                        if (grp_digits > 0 && grp_cnt != 4'd15) grp_cnt++;
                        grp_digits = '0;
                    end else if (grp_val == 2) begin
                        if (dc_seen) log_fault(FAULT_SECOND_DC);
                        dc_seen = 1'b1;
                    end else begin
                        log_fault(FAULT_SECOND_DC);
                    end
                end else begin
                    log_fault(FAULT_BAD_CHAR);
                end
                if (d.last_char && cur_fault == FAULT_NONE) begin
                    groups = int'(grp_cnt) + ((grp_digits > 0) ? 1 : 0);
                    if (grp_val == 1) log_fault(FAULT_EMPTY_GROUP);
                    else if (dc_seen ? (groups > 7) : (groups != 8)) log_fault(FAULT_GROUP_COUNT);
                end
            end
            if (d.last_char) begin
                exp_r.address_valid = (cur_fault == FAULT_NONE);
                exp_r.fault_code    = cur_fault;
                verdict_q.insert(verdict_q.size(), exp_r);
                clear_text();
            end
        endfunction

        function void check_result(out_data_t r);
            out_data_t e;
            if (verdict_q.size() == 0) begin
                $display("%0t: unexpected result valid=%0d fault=%0d", $time,
                         r.address_valid, r.fault_code);
                failures++;
            end else begin
                e = verdict_q.pop_front();
                texts_checked++;
                if (r.address_valid !== e.address_valid) begin
                    $display("%0t: address_valid expected %0d actual %0d", $time,
                             e.address_valid, r.address_valid);
                    failures++;
                end
                if (r.fault_code !== e.fault_code) begin
                    $display("%0t: fault_code expected %0d actual %0d", $time,
                             e.fault_code, r.fault_code);
                    failures++;
                end
            end
        endfunction
    endclass

    logic      aclk = 1'b0;
    logic      aresetn;
    logic      cfg_valid;
    logic      cfg_ready;
    logic      cfg_data;
    logic      s_valid;
    logic      s_ready;
    in_data_t  s_data;
    logic      m_valid;
    logic      m_ready;
    out_data_t m_data;

    address_verdict_board board = new();
    int src_idle_pct;
    int snk_stall_pct;
    int chars_sent;

    ip_address_text_validator_top u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    always @(negedge aclk) begin
        m_ready = ($urandom_range(0, 99) >= snk_stall_pct);
    end

    // Checks come before notes so a verdict never meets its own character in one cycle.
    always @(posedge aclk) begin
        if (aresetn === 1'b1) begin
            if (m_valid && m_ready) board.check_result(m_data);
            if (s_valid && s_ready) board.note_char(s_data);
            if (cfg_valid && cfg_ready) board.note_mode(cfg_data);
        end
    end

    // All drive tasks are entered and left at a falling edge.
    task automatic send_char(input logic [7:0] c, input logic last);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            s_valid = 1'b0;
            @(negedge aclk);
        end
        s_valid = 1'b1;
        s_data  = '{char_code: c, last_char: last};
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        @(negedge aclk);
        chars_sent++;
    endtask

    task automatic send_text(ref char_q_t t);
        for (int i = 0; i < t.size(); i++) send_char(t[i], i == t.size() - 1);
    endtask

    task automatic send_string(input string s);
        for (int i = 0; i < s.len(); i++) send_char(s[i], i == s.len() - 1);
    endtask

    // A character that closes no text may still be in flight once the queue is empty.
    task automatic wait_drained();
        s_valid = 1'b0;
        @(negedge aclk);
        while (board.pending() != 0) @(negedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    task automatic write_mode(input logic m);
        wait_drained();
        cfg_valid = 1'b1;
        cfg_data  = m;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    task automatic append_char(ref char_q_t t, input logic [7:0] c);
        t.insert(t.size(), c);
    endtask

    task automatic push_str(ref char_q_t t, input string s);
        for (int i = 0; i < s.len(); i++) append_char(t, s[i]);
    endtask

    task automatic push_v4_group(ref char_q_t t);
        int sel;
        sel = $urandom_range(0, 9);
        case (sel)
            0: push_str(t, "0");
            1: push_str(t, "255");
            2: push_str(t, $sformatf("%0d", $urandom_range(256, 999)));
            3: begin
                repeat ($urandom_range(1, 2)) append_char(t, ASCII_0);
                push_str(t, $sformatf("%0d", $urandom_range(0, 255)));
            end
            4: repeat ($urandom_range(8, 10)) append_char(t, ASCII_0 + 8'($urandom_range(0, 9)));
            default: push_str(t, $sformatf("%0d", $urandom_range(0, 255)));
        endcase
    endtask

    task automatic make_ipv4(ref char_q_t t);
        int kind;
        int n;
        int sel;
        kind = $urandom_range(0, 9);
        if (kind == 9) begin
            repeat ($urandom_range(1, 40)) begin
                sel = $urandom_range(0, 3);
                if (sel < 2) append_char(t, ASCII_0 + 8'($urandom_range(0, 9)));
                else if (sel == 2) append_char(t, ASCII_DOT);
                else append_char(t, 8'($urandom_range(0, 255)));
            end
        end else begin
            n = (kind == 6) ? $urandom_range(1, 6) : 4;
            for (int g = 0; g < n; g++) begin
                if (g != 0) append_char(t, ASCII_DOT);
                push_v4_group(t);
            end
            if (kind == 7) begin
                case ($urandom_range(0, 2))
                    0: t.push_front(ASCII_DOT);
                    1: append_char(t, ASCII_DOT);
                    default: t.insert($urandom_range(0, t.size() - 1), ASCII_DOT);
                endcase
            end else if (kind == 8) begin
                t.insert($urandom_range(0, t.size() - 1), 8'($urandom_range(0, 255)));
            end
        end
    endtask

    // Pushes cnt hex groups split by single colons; group long_idx gets five or more digits.
    task automatic push_v6_groups(ref char_q_t t, input int cnt, input int long_idx);
        string hex_set;
        int    len;
        hex_set = "0123456789abcdefABCDEF";
        for (int g = 0; g < cnt; g++) begin
            if (g != 0) append_char(t, ASCII_COLON);
            len = (g == long_idx) ? $urandom_range(5, 9) : $urandom_range(1, 4);
            repeat (len) append_char(t, hex_set[$urandom_range(0, 21)]);
        end
    endtask

    task automatic make_v6_compressed(ref char_q_t t, input int total, input int run);
        int lead;
        lead = $urandom_range(0, total);
        push_v6_groups(t, lead, -1);
        repeat (run) append_char(t, ASCII_COLON);
        push_v6_groups(t, total - lead, -1);
    endtask

    task automatic make_ipv6(ref char_q_t t);
        int kind;
        int sel;
        kind = $urandom_range(0, 9);
        case (kind)
            0, 1, 2, 3: push_v6_groups(t, 8, -1);
            4, 5: make_v6_compressed(t, $urandom_range(0, 7), 2);
            6: begin
                if ($urandom_range(0, 1) == 0) begin
                    make_v6_compressed(t, $urandom_range(0, 6), 3);
                end else begin
                    push_v6_groups(t, $urandom_range(0, 2), -1);
                    push_str(t, "::");
                    push_v6_groups(t, 1, -1);
                    push_str(t, "::");
                    push_v6_groups(t, $urandom_range(0, 2), -1);
                end
            end
            7: begin
                sel = $urandom_range(0, 4);
                case (sel)
                    0: begin
                        append_char(t, ASCII_COLON);
                        push_v6_groups(t, 8, -1);
                    end
                    1: begin
                        push_v6_groups(t, 8, -1);
                        append_char(t, ASCII_COLON);
                    end
                    2: push_v6_groups(t, 7, -1);
                    3: push_v6_groups(t, 9, -1);
                    default: make_v6_compressed(t, 8, 2);
                endcase
            end
            8: push_v6_groups(t, 8, $urandom_range(0, 7));
            default: begin
                if ($urandom_range(0, 1) == 0) begin
                    push_v6_groups(t, 8, -1);
                    t.insert($urandom_range(0, t.size() - 1), 8'($urandom_range(0, 255)));
                end else begin
                    repeat ($urandom_range(1, 40)) begin
                        sel = $urandom_range(0, 3);
                        if (sel < 2) push_v6_groups(t, 1, -1);
                        else if (sel == 2) append_char(t, ASCII_COLON);
                        else append_char(t, 8'($urandom_range(0, 255)));
                    end
                end
            end
        endcase
    endtask

    initial begin
        #2_000_000;
        $display("Timeout with %0d verdicts still outstanding.", board.pending());
        $display("FAIL ip_address_text_validator_top");
        $finish;
    end

    initial begin
        char_q_t txt;
        int      block_start;
        aresetn       = 1'b0;
        cfg_valid     = 1'b0;
        cfg_data      = MODE_IPV4;
        s_valid       = 1'b0;
        s_data        = '0;
        m_ready       = 1'b1;
        src_idle_pct  = 0;
        snk_stall_pct = 0;
        chars_sent    = 0;
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Directed texts: value extremes, single characters, empty groups and colon runs.
        write_mode(MODE_IPV4);
        send_string("255.0.0.9");
        send_string("256");
        send_string(".");
        send_char(8'hFF, 1'b1);
        write_mode(MODE_IPV6);
        send_string("::");
        send_string(":::");
        send_string(":1");
        send_string("1:");
        send_string("ab0Ff");
        send_char(8'h00, 1'b1);

        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin
                    src_idle_pct  = 0;
                    snk_stall_pct = 0;
                end
                1: begin
                    src_idle_pct  = 47;
                    snk_stall_pct = 0;
                end
                2: begin
                    src_idle_pct  = 0;
                    snk_stall_pct = 47;
                end
                default: begin
                    src_idle_pct  = 19;
                    snk_stall_pct = 19;
                end
            endcase
            for (int m = 0; m < 2; m++) begin
                write_mode(m[0] ? MODE_IPV6 : MODE_IPV4);
                block_start = chars_sent;
                while (chars_sent - block_start < ITEMS_PER_BLOCK) begin
                    txt.delete();
                    if (m[0]) make_ipv6(txt);
                    else make_ipv4(txt);
                    send_text(txt);
                end
            end
        end

        wait_drained();
        repeat (10) @(negedge aclk);
        if (board.pending() != 0) begin
            $display("%0t: %0d verdicts never arrived", $time, board.pending());
            board.failures++;
        end
        $display("Sent %0d characters and checked %0d verdicts in both address modes,",
                 chars_sent, board.texts_checked);
        $display("under four sender and receiver idle patterns; %0d mismatches.", board.failures);
        if (board.failures == 0) begin
            $display("PASS ip_address_text_validator_top");
        end else begin
            $display("FAIL ip_address_text_validator_top");
        end
        $finish;
    end

endmodule
